FILE: design/clsr_pkg.sv
// Shared constants, command and status types for the combined LCG shuffle generator.
package clsr_pkg;

    localparam int TableEntriesDefault = 32;
    localparam int Warmup = 8;

    localparam logic [30:0] ModOne = 31'd2147483563;
    localparam logic [30:0] ModTwo = 31'd2147483399;
    localparam logic [15:0] MulOne = 16'd40014;
    localparam logic [15:0] MulTwo = 16'd40692;
    localparam logic [7:0] FoldOne = 8'd85;
    localparam logic [7:0] FoldTwo = 8'd249;
    localparam logic [30:0] SecondReset = 31'd123456789;

    localparam longint unsigned ClampNum = 64'd24999997;
    localparam longint unsigned ClampDen = 64'd25000000;
    localparam longint unsigned ClampMinL =
        64'(ModOne) - ((ClampDen - ClampNum) * 64'(ModOne)) / ClampDen;
    localparam logic [30:0] ClampMin = 31'(ClampMinL);
    localparam int ClampPreShift = 6;
    localparam longint unsigned ClampDiv = ClampDen >> ClampPreShift;
    localparam int ClampShift = 49;
    localparam longint unsigned ClampRecipL =
        ((64'd1 << ClampShift) + ClampDiv - 64'd1) / ClampDiv;
    localparam logic [30:0] ClampRecip = 31'(ClampRecipL);
    localparam logic [33:0] ClampBias = 34'(ClampDen - 64'd1);

    localparam logic [0:0] RegRangeLow = 1'b0;
    localparam logic [0:0] RegRangeHigh = 1'b1;
    localparam logic [31:0] RangeLowReset = 32'd0;
    localparam logic [31:0] RangeHighReset = 32'd65536;

    typedef struct packed {
        logic seed_load;
        logic adv1;
        logic adv2;
        logic tbl_wr_seed;
        logic seed_last;
        logic tbl_rd;
        logic draw_upd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic gen1_zero;
        logic out_free;
    } status_t;

endpackage

FILE: design/combined_lcg_shuffle_rng_unit.sv
// Top level of the combined LCG generator with shuffle table and scaled output.
// One input beat is taken at a time: s_tready stays low while the generator multiply-reduce,
// shuffle memory read-modify-write and the three-stage scaling reduction run one after another,
// and until the result is loaded into the output register.
// Seeding (opcode 1, or the first draw) adds TABLE_ENTRIES + 8 generator steps; the first 8 only warm up.
// Reset: generator unseeded, range_low 0 and range_high 1.0; the shuffle memory is not cleared.
module combined_lcg_shuffle_rng_unit #(
    parameter int TABLE_ENTRIES = clsr_pkg::TableEntriesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] seed_value, [31] zero
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [30:0] raw_value, [62:31] scaled_value, [63] zero
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    clsr_pkg::cmd_t cmd;
    clsr_pkg::status_t status;
    logic [$clog2(TABLE_ENTRIES)-1:0] seed_addr;

    clsr_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .status   (status),
        .cmd      (cmd),
        .seed_addr(seed_addr)
    );

    clsr_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .opcode    (s_tuser),
        .seed_value(s_tdata[30:0]),
        .cmd       (cmd),
        .seed_addr (seed_addr),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: design/clsr_ctrl.sv
// Sequencer for seeding, drawing and scaling in the combined LCG shuffle generator.
module clsr_ctrl #(
    parameter int TABLE_ENTRIES = clsr_pkg::TableEntriesDefault
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic                             opcode,
    input  clsr_pkg::status_t                status,
    output clsr_pkg::cmd_t                   cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0] seed_addr
);

    localparam int SlotBits = $clog2(TABLE_ENTRIES);
    localparam int SeedSteps = TABLE_ENTRIES + clsr_pkg::Warmup;
    localparam int CntBits = $clog2(SeedSteps);
    localparam logic [CntBits-1:0] CntLast = CntBits'(SeedSteps - 1);
    localparam logic [CntBits-1:0] CntWarm = CntBits'(clsr_pkg::Warmup);
    localparam logic [CntBits-1:0] CntOne = CntBits'(1);

    localparam logic [3:0] StIdle    = 4'd0;
    localparam logic [3:0] StSeedMul = 4'd1;
    localparam logic [3:0] StSeedRed = 4'd2;
    localparam logic [3:0] StDrawMul = 4'd3;
    localparam logic [3:0] StDrawRed = 4'd4;
    localparam logic [3:0] StDrawUpd = 4'd5;
    localparam logic [3:0] StScMul   = 4'd6;
    localparam logic [3:0] StScFold1 = 4'd7;
    localparam logic [3:0] StScFold2 = 4'd8;
    localparam logic [3:0] StScFix   = 4'd9;
    localparam logic [3:0] StScOut   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [CntBits-1:0] cnt_reg, cnt_next;
    logic [CntBits-1:0] addr_full;

    assign s_tready = (state_reg == StIdle);
    assign addr_full = CntLast - cnt_reg;
    assign seed_addr = addr_full[SlotBits-1:0];

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        case (state_reg)
            StIdle: begin
                if (s_tvalid) begin
                    cnt_next = '0;
                    if (opcode || status.gen1_zero) begin
                        cmd.seed_load = 1'b1;
                        state_next = StSeedMul;
                    end else begin
                        state_next = StDrawMul;
                    end
                end
            end
            StSeedMul: state_next = StSeedRed;
            StSeedRed: begin
                cmd.adv1 = 1'b1;
                cmd.tbl_wr_seed = (cnt_reg >= CntWarm);
                if (cnt_reg == CntLast) begin
                    cmd.seed_last = 1'b1;
                    state_next = StDrawMul;
                end else begin
                    cnt_next = cnt_reg + CntOne;
                    state_next = StSeedMul;
                end
            end
            StDrawMul: state_next = StDrawRed;
            StDrawRed: begin
                cmd.adv1 = 1'b1;
                cmd.adv2 = 1'b1;
                cmd.tbl_rd = 1'b1;
                state_next = StDrawUpd;
            end
            StDrawUpd: begin
                cmd.draw_upd = 1'b1;
                state_next = StScMul;
            end
            StScMul:   state_next = StScFold1;
            StScFold1: state_next = StScFold2;
            StScFold2: state_next = StScFix;
            StScFix:   state_next = StScOut;
            StScOut: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = StIdle;
                end
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StIdle;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/clsr_datapath.sv
// Generators, shuffle memory, slot and scaling arithmetic, and output register.
module clsr_datapath #(
    parameter int TABLE_ENTRIES = clsr_pkg::TableEntriesDefault
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [0:0]                       cfg_addr,
    input  logic [31:0]                      cfg_wdata,
    input  logic                             opcode,
    input  logic [30:0]                      seed_value,
    input  clsr_pkg::cmd_t                   cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] seed_addr,
    output clsr_pkg::status_t                status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata
);

    localparam int SlotBits = $clog2(TABLE_ENTRIES);
    localparam longint unsigned SlotDiv =
        64'd1 + (64'(clsr_pkg::ModOne) - 64'd1) / 64'(TABLE_ENTRIES);
    localparam int SlotShift = 31 + $clog2(SlotDiv);
    localparam longint unsigned SlotRecipL =
        ((64'd1 << SlotShift) + SlotDiv - 64'd1) / SlotDiv;
    localparam logic [32:0] SlotRecip = 33'(SlotRecipL);
    localparam logic [63:0] SlotLast = 64'(TABLE_ENTRIES - 1);

    logic [30:0] gen1_reg, gen1_next;
    logic [30:0] gen2_reg, gen2_next;
    logic [30:0] out_reg, out_next;
    logic [46:0] prod1_reg, prod2_reg;
    logic [63:0] slot_prod_reg;
    logic [30:0] rd_reg;
    logic [SlotBits-1:0] slot_reg;
    logic [30:0] shuf_mem_reg [TABLE_ENTRIES];
    logic [31:0] range_low_reg, range_high_reg;
    logic [32:0] span_reg;
    logic [31:0] mag_reg;
    logic        neg_reg;
    logic [27:0] xc_reg;
    logic [62:0] sprod_reg;
    logic        clamp_reg;
    logic [31:0] q1_reg, q2_reg, x2_reg, term_reg;
    logic [39:0] x1_reg;
    logic        mval_reg, mval_next;
    logic [63:0] mdata_reg;

    logic [30:0] seed_eff;
    logic [31:0] s1, s2;
    logic [30:0] red1, red2;
    logic [63:0] slot_q;
    logic [SlotBits-1:0] slot_idx;
    logic [31:0] diff;
    logic [30:0] y;
    logic        clamp;
    logic [31:0] op_a;
    logic [30:0] op_b;
    logic [32:0] span_abs;
    logic [33:0] xc_sum;
    logic [31:0] hi1;
    logic [9:0]  cq;
    logic [8:0]  hi2;
    logic [31:0] result;
    logic        mem_we;
    logic [SlotBits-1:0] mem_waddr;
    logic [30:0] mem_wdata;

    assign seed_eff = (opcode && (seed_value != '0)) ? seed_value : 31'd1;

    assign s1 = 32'(prod1_reg[46:31]) * 32'(clsr_pkg::FoldOne) + 32'(prod1_reg[30:0]);
    assign red1 = (s1 >= 32'(clsr_pkg::ModOne)) ? 31'(s1 - 32'(clsr_pkg::ModOne)) : s1[30:0];
    assign s2 = 32'(prod2_reg[46:31]) * 32'(clsr_pkg::FoldTwo) + 32'(prod2_reg[30:0]);
    assign red2 = (s2 >= 32'(clsr_pkg::ModTwo)) ? 31'(s2 - 32'(clsr_pkg::ModTwo)) : s2[30:0];

    assign slot_q = slot_prod_reg >> SlotShift;
    assign slot_idx = (slot_q > SlotLast) ? SlotBits'(TABLE_ENTRIES - 1) : slot_q[SlotBits-1:0];

    assign diff = 32'(rd_reg) - 32'(gen2_reg);
    assign y = ($signed(diff) < 32'sd1) ? 31'(diff + 32'(clsr_pkg::ModOne) - 32'd1) : diff[30:0];

    assign clamp = (out_reg >= clsr_pkg::ClampMin);
    assign op_a = clamp ? 32'(xc_reg) : mag_reg;
    assign op_b = clamp ? clsr_pkg::ClampRecip : out_reg;

    assign span_abs = span_reg[32] ? (33'd0 - span_reg) : span_reg;
    assign xc_sum = 34'(mag_reg) * 34'd3 + clsr_pkg::ClampBias;

    assign hi1 = sprod_reg[62:31];
    assign cq = 10'(sprod_reg >> clsr_pkg::ClampShift);
    assign hi2 = x1_reg[39:31];

    assign result = neg_reg ? (range_low_reg - term_reg) : (range_low_reg + term_reg);

    assign status.gen1_zero = (gen1_reg == '0);
    assign status.out_free = !mval_reg || m_tready;
    assign m_tvalid = mval_reg;
    assign m_tdata = mdata_reg;

    always_comb begin
        gen1_next = gen1_reg;
        gen2_next = gen2_reg;
        out_next = out_reg;
        if (cmd.seed_load) begin
            gen1_next = seed_eff;
            gen2_next = seed_eff;
        end
        if (cmd.adv1) begin
            gen1_next = red1;
        end
        if (cmd.adv2) begin
            gen2_next = red2;
        end
        if (cmd.seed_last) begin
            out_next = red1;
        end
        if (cmd.draw_upd) begin
            out_next = y;
        end
    end

    always_comb begin
        mval_next = mval_reg;
        if (cmd.out_load) begin
            mval_next = 1'b1;
        end else if (m_tready) begin
            mval_next = 1'b0;
        end
    end

    assign mem_we = cmd.tbl_wr_seed || cmd.draw_upd;
    assign mem_waddr = cmd.draw_upd ? slot_reg : seed_addr;
    assign mem_wdata = cmd.draw_upd ? gen1_reg : red1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen1_reg <= '0;
            gen2_reg <= clsr_pkg::SecondReset;
            out_reg <= '0;
            mval_reg <= 1'b0;
            range_low_reg <= clsr_pkg::RangeLowReset;
            range_high_reg <= clsr_pkg::RangeHighReset;
        end else begin
            gen1_reg <= gen1_next;
            gen2_reg <= gen2_next;
            out_reg <= out_next;
            mval_reg <= mval_next;
            if (cfg_we) begin
                case (cfg_addr)
                    clsr_pkg::RegRangeLow:  range_low_reg <= cfg_wdata;
                    clsr_pkg::RegRangeHigh: range_high_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            shuf_mem_reg[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tbl_rd) begin
            rd_reg <= shuf_mem_reg[slot_idx];
            slot_reg <= slot_idx;
        end
    end

    always_ff @(posedge aclk) begin
        prod1_reg <= 47'(gen1_reg) * 47'(clsr_pkg::MulOne);
        prod2_reg <= 47'(gen2_reg) * 47'(clsr_pkg::MulTwo);
        slot_prod_reg <= 64'(out_reg) * 64'(SlotRecip);
        span_reg <= {range_high_reg[31], range_high_reg} - {range_low_reg[31], range_low_reg};
        mag_reg <= span_abs[31:0];
        neg_reg <= span_reg[32];
        xc_reg <= xc_sum[33:clsr_pkg::ClampPreShift];
        sprod_reg <= 63'(op_a) * 63'(op_b);
        clamp_reg <= clamp;
        q1_reg <= clamp_reg ? (mag_reg - 32'(cq)) : hi1;
        x1_reg <= clamp_reg ? 40'd0
                            : 40'(hi1) * 40'(clsr_pkg::FoldOne) + 40'(sprod_reg[30:0]);
        q2_reg <= q1_reg + 32'(hi2);
        x2_reg <= 32'(hi2) * 32'(clsr_pkg::FoldOne) + 32'(x1_reg[30:0]);
        term_reg <= q2_reg + ((x2_reg >= 32'(clsr_pkg::ModOne)) ? 32'd1 : 32'd0);
        if (cmd.out_load) begin
            mdata_reg <= {1'b0, result, out_reg};
        end
    end

endmodule
